[rtl/csc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the calendar/seconds converter
// Transaction payloads, pipeline control bundle, reciprocal constants used
// for the divide-by-constant steps, and the month offset table.
// ----------------------------------------------------------------------------
package csc_pkg;

    // Direction codes carried in the op field
    localparam logic OP_TO_CAL = 1'b0;
    localparam logic OP_TO_SEC = 1'b1;

    // Register stages in each conversion datapath (output register not counted)
    localparam int NUM_STAGES = 8;

    // Last count that still lands in year 9999
    localparam logic [38:0] MAX_SECONDS = 39'd315537897599;

    // 2^39 - 86400: one day before the epoch, wrapped
    localparam logic [38:0] NEG_DAY_SECS = 39'd549755727488;

    // Reciprocals: floor(x / C) == (x * RECIP_C) >> SHIFT over the value range used
    localparam logic [32:0] RECIP_675    = 33'd6515624461;  // shift 42, x < 2^32
    localparam logic [22:0] RECIP_146097 = 23'd7525902;     // shift 40, x < 2^22
    localparam logic [15:0] RECIP_3600   = 16'd37283;       // shift 27, x < 86400
    localparam logic [12:0] RECIP_60     = 13'd4370;        // shift 18, x < 3600
    localparam logic [15:0] RECIP_1461   = 16'd45934;       // shift 26, x < 36525
    localparam logic [13:0] RECIP_100    = 14'd10486;       // shift 20, x < 2^14

    typedef struct packed {
        logic        op;
        logic [38:0] in_seconds;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_sec;
    } t_req;

    typedef struct packed {
        logic [38:0] out_seconds;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_sec;
        logic        range_error;
    } t_rsp;

    // Calendar fields leaving the seconds-to-calendar datapath
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
        logic        err;
    } t_cal;

    // Per-stage load enables and occupancy; the last bit is the output register
    typedef struct packed {
        logic [NUM_STAGES:0] load;
        logic [NUM_STAGES:0] valid;
    } t_pipe_ctrl;

    // Days in the year before the first of month m; months past twelve
    // count the whole year, month zero counts nothing
    function automatic logic [8:0] month_offset(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        unique case (m)
            4'd0, 4'd1: base = 9'd0;
            4'd2:       base = 9'd31;
            4'd3:       base = 9'd59;
            4'd4:       base = 9'd90;
            4'd5:       base = 9'd120;
            4'd6:       base = 9'd151;
            4'd7:       base = 9'd181;
            4'd8:       base = 9'd212;
            4'd9:       base = 9'd243;
            4'd10:      base = 9'd273;
            4'd11:      base = 9'd304;
            4'd12:      base = 9'd334;
            default:    base = 9'd365;
        endcase
        return base + 9'((m > 4'd2) && leap);
    endfunction

endpackage

[rtl/csc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_req_if: request channel
// Valid/ready channel carrying one conversion request per transaction.
// ----------------------------------------------------------------------------
interface csc_req_if;
    import csc_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/csc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_rsp_if: result channel
// Valid/ready channel carrying one conversion result per transaction.
// ----------------------------------------------------------------------------
interface csc_rsp_if;
    import csc_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/calendar_seconds_conversion_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_seconds_conversion_top: proleptic Gregorian seconds <-> date/time
// Converts a count of seconds since 0001-01-01 00:00:00 to a calendar date
// and time (op 0), or a date and time to such a count (op 1).
// ----------------------------------------------------------------------------
// The converter takes one request per clock cycle while ready is high and
// returns each result through eight pipeline stages of reciprocal
// multiplies and compares, then the output register. A stalled output only
// holds the stages that are occupied; empty stages keep taking requests, so
// ready drops only once all nine stages hold a transaction. Results leave in
// request order. Counts past 9999-12-31 23:59:59 return range_error with all
// other fields zero; in the calendar-to-seconds direction the day, hour,
// minute and second are added linearly without range checks.
module calendar_seconds_conversion_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csc_req_if.sink    i_req,
    csc_rsp_if.source  o_rsp
);
    import csc_pkg::*;

    t_pipe_ctrl              w_ctrl;
    logic                    w_in_ready;
    t_cal                    w_cal;
    logic [38:0]             w_seconds;
    logic [NUM_STAGES-1:0]   r_op;
    t_rsp                    n_rsp;
    t_rsp                    r_rsp;

    csc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (w_in_ready),
        .o_ctrl      (w_ctrl)
    );

    csc_to_cal u_to_cal (
        .i_clk     (i_clk),
        .i_load    (w_ctrl.load[NUM_STAGES-1:0]),
        .i_seconds (i_req.payload.in_seconds),
        .o_cal     (w_cal)
    );

    csc_to_sec u_to_sec (
        .i_clk     (i_clk),
        .i_load    (w_ctrl.load[NUM_STAGES-1:0]),
        .i_year    (i_req.payload.in_year),
        .i_month   (i_req.payload.in_month),
        .i_day     (i_req.payload.in_day),
        .i_hour    (i_req.payload.in_hour),
        .i_minute  (i_req.payload.in_minute),
        .i_sec     (i_req.payload.in_sec),
        .o_seconds (w_seconds)
    );

    // Carry the direction alongside the datapath stages
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[0]) begin
            r_op[0] <= i_req.payload.op;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_ctrl.load[k]) begin
                r_op[k] <= r_op[k - 1];
            end
        end
    end

    // Select the direction; unused fields stay zero
    always_comb begin
        n_rsp = '0;
        if (r_op[NUM_STAGES-1] == OP_TO_SEC) begin
            n_rsp.out_seconds = w_seconds;
        end else if (w_cal.err) begin
            n_rsp.range_error = 1'b1;
        end else begin
            n_rsp.out_year   = w_cal.year;
            n_rsp.out_month  = w_cal.month;
            n_rsp.out_day    = w_cal.day;
            n_rsp.out_hour   = w_cal.hour;
            n_rsp.out_minute = w_cal.minute;
            n_rsp.out_sec    = w_cal.sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[NUM_STAGES]) begin
            r_rsp <= n_rsp;
        end
    end

    assign i_req.ready   = w_in_ready;
    assign o_rsp.valid   = w_ctrl.valid[NUM_STAGES];
    assign o_rsp.payload = r_rsp;

    // Back-pressure reaches the input only when every stage is occupied
    a_ready_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&w_ctrl.valid)
    ) else $error("request stalled while a pipeline stage is empty");

    // An accepted transaction occupies the first stage on the next cycle
    a_accept_enters_stage: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> w_ctrl.valid[0]
    ) else $error("accepted transaction did not enter the pipeline");

    // Out-of-range result carries no date or count
    a_range_error_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.range_error) |->
            (o_rsp.payload.out_seconds == 39'd0) && (o_rsp.payload.out_year == 14'd0)
            && (o_rsp.payload.out_month == 4'd0) && (o_rsp.payload.out_day == 5'd0)
    ) else $error("range error with nonzero result fields");

    // A produced date has a month and day in range
    a_calendar_fields: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.payload.out_year != 14'd0)) |->
            (o_rsp.payload.out_month >= 4'd1) && (o_rsp.payload.out_month <= 4'd12)
            && (o_rsp.payload.out_day >= 5'd1) && (o_rsp.payload.out_day <= 5'd31)
    ) else $error("calendar result out of range");

endmodule

[rtl/csc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ctrl: pipeline occupancy and flow control
// Tracks a valid bit per stage and derives per-stage load enables so that
// empty stages keep filling while the output is stalled.
// ----------------------------------------------------------------------------
module csc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output csc_pkg::t_pipe_ctrl   o_ctrl
);
    import csc_pkg::*;

    logic [NUM_STAGES:0] r_valid;
    logic [NUM_STAGES:0] n_valid;
    logic [NUM_STAGES:0] w_load;

    // A stage loads when it is empty or its content moves on this cycle
    always_comb begin
        w_load[NUM_STAGES] = !r_valid[NUM_STAGES] || i_out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k + 1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_load[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k <= NUM_STAGES; k++) begin
            if (w_load[k]) begin
                n_valid[k] = r_valid[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready   = w_load[0];
    assign o_ctrl.load  = w_load;
    assign o_ctrl.valid = r_valid;
endmodule

[rtl/csc_to_cal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_to_cal: seconds-to-calendar datapath
// Eight register stages: day split, 400/100/4/1-year cycles, time of day,
// then month search; the day of month is formed at the output.
// ----------------------------------------------------------------------------
module csc_to_cal (
    input  logic                              i_clk,
    input  logic [csc_pkg::NUM_STAGES-1:0]    i_load,
    input  logic [38:0]                       i_seconds,
    output csc_pkg::t_cal                     o_cal
);
    import csc_pkg::*;

    // stage 1
    logic [64:0] w_p1;
    logic [22:0] r1_q;
    logic [31:0] r1_x;
    logic [6:0]  r1_lo;
    logic        r1_err;
    // stage 2
    logic [32:0] w_m675;
    logic [31:0] w_rem;
    logic [44:0] w_p400;
    logic [21:0] r2_d;
    logic [16:0] r2_tod;
    logic [4:0]  r2_q400;
    logic        r2_err;
    // stage 3
    logic [22:0] w_m400;
    logic [21:0] w_d400;
    logic [32:0] w_ph;
    logic [17:0] r3_d400;
    logic [16:0] r3_tod;
    logic [4:0]  r3_hour;
    logic [4:0]  r3_q400;
    logic        r3_err;
    // stage 4
    logic [1:0]  w_q100;
    logic [17:0] w_m100;
    logic [17:0] w_d100;
    logic [16:0] w_mh;
    logic [16:0] w_remh;
    logic [15:0] r4_d100;
    logic [1:0]  r4_q100;
    logic [11:0] r4_remh;
    logic [4:0]  r4_hour;
    logic [4:0]  r4_q400;
    logic        r4_err;
    // stage 5
    logic [31:0] w_p4;
    logic [24:0] w_pm;
    logic [4:0]  r5_q4;
    logic [15:0] r5_d100;
    logic [5:0]  r5_min;
    logic [11:0] r5_remh;
    logic [1:0]  r5_q100;
    logic [4:0]  r5_hour;
    logic [4:0]  r5_q400;
    logic        r5_err;
    // stage 6
    logic [15:0] w_m4;
    logic [15:0] w_d4;
    logic [11:0] w_ms;
    logic [11:0] w_sec;
    logic [10:0] r6_d4;
    logic [4:0]  r6_q4;
    logic [5:0]  r6_sec;
    logic [5:0]  r6_min;
    logic [1:0]  r6_q100;
    logic [4:0]  r6_hour;
    logic [4:0]  r6_q400;
    logic        r6_err;
    // stage 7
    logic [1:0]  w_q1;
    logic [10:0] w_m1;
    logic [10:0] w_doy;
    logic [13:0] w_year;
    logic        w_leap;
    logic [13:0] r7_year;
    logic [8:0]  r7_doy;
    logic        r7_leap;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;
    logic        r7_err;
    // stage 8
    logic [10:0] w_ge;
    logic [13:0] r8_year;
    logic [3:0]  r8_month;
    logic [8:0]  r8_doy;
    logic        r8_leap;
    logic [4:0]  r8_hour;
    logic [5:0]  r8_min;
    logic [5:0]  r8_sec;
    logic        r8_err;
    // output
    logic [8:0]  w_day;

    // Stage 1: seconds / 86400 as (s >> 7) / 675
    assign w_p1 = 65'(i_seconds[38:7]) * 65'(RECIP_675);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r1_q   <= w_p1[64:42];
            r1_x   <= i_seconds[38:7];
            r1_lo  <= i_seconds[6:0];
            r1_err <= i_seconds > MAX_SECONDS;
        end
    end

    // Stage 2: time of day from the remainder, 400-year cycle count
    assign w_m675 = 33'(r1_q) * 33'd675;
    assign w_rem  = r1_x - w_m675[31:0];
    assign w_p400 = 45'(r1_q[21:0]) * 45'(RECIP_146097);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r2_d    <= r1_q[21:0];
            r2_tod  <= {w_rem[9:0], r1_lo};
            r2_q400 <= w_p400[44:40];
            r2_err  <= r1_err;
        end
    end

    // Stage 3: day within the 400-year cycle, hour
    assign w_m400 = 23'(r2_q400) * 23'd146097;
    assign w_d400 = r2_d - w_m400[21:0];
    assign w_ph   = 33'(r2_tod) * 33'(RECIP_3600);

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r3_d400 <= w_d400[17:0];
            r3_tod  <= r2_tod;
            r3_hour <= w_ph[31:27];
            r3_q400 <= r2_q400;
            r3_err  <= r2_err;
        end
    end

    // Stage 4: century within the cycle, clamped to three
    always_comb begin
        if (r3_d400 >= 18'd109572) begin
            w_q100 = 2'd3;
        end else if (r3_d400 >= 18'd73048) begin
            w_q100 = 2'd2;
        end else if (r3_d400 >= 18'd36524) begin
            w_q100 = 2'd1;
        end else begin
            w_q100 = 2'd0;
        end
    end

    assign w_m100 = 18'(w_q100) * 18'd36524;
    assign w_d100 = r3_d400 - w_m100;
    assign w_mh   = 17'(r3_hour) * 17'd3600;
    assign w_remh = r3_tod - w_mh;

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r4_d100 <= w_d100[15:0];
            r4_q100 <= w_q100;
            r4_remh <= w_remh[11:0];
            r4_hour <= r3_hour;
            r4_q400 <= r3_q400;
            r4_err  <= r3_err;
        end
    end

    // Stage 5: four-year cycle count, minute
    assign w_p4 = 32'(r4_d100) * 32'(RECIP_1461);
    assign w_pm = 25'(r4_remh) * 25'(RECIP_60);

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r5_q4   <= w_p4[30:26];
            r5_d100 <= r4_d100;
            r5_min  <= w_pm[23:18];
            r5_remh <= r4_remh;
            r5_q100 <= r4_q100;
            r5_hour <= r4_hour;
            r5_q400 <= r4_q400;
            r5_err  <= r4_err;
        end
    end

    // Stage 6: day within the four-year cycle, second
    assign w_m4  = 16'(r5_q4) * 16'd1461;
    assign w_d4  = r5_d100 - w_m4;
    assign w_ms  = 12'(r5_min) * 12'd60;
    assign w_sec = r5_remh - w_ms;

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r6_d4   <= w_d4[10:0];
            r6_q4   <= r5_q4;
            r6_sec  <= w_sec[5:0];
            r6_min  <= r5_min;
            r6_q100 <= r5_q100;
            r6_hour <= r5_hour;
            r6_q400 <= r5_q400;
            r6_err  <= r5_err;
        end
    end

    // Stage 7: year within the four-year cycle, year number, leap flag
    always_comb begin
        if (r6_d4 >= 11'd1095) begin
            w_q1 = 2'd3;
        end else if (r6_d4 >= 11'd730) begin
            w_q1 = 2'd2;
        end else if (r6_d4 >= 11'd365) begin
            w_q1 = 2'd1;
        end else begin
            w_q1 = 2'd0;
        end
    end

    assign w_m1   = 11'(w_q1) * 11'd365;
    assign w_doy  = r6_d4 - w_m1;
    assign w_year = 14'(r6_q400) * 14'd400 + 14'(r6_q100) * 14'd100
                  + {7'd0, r6_q4, 2'b00} + 14'(w_q1) + 14'd1;
    // Last year of a four-year cycle is a leap year unless it closes a
    // century that does not close a 400-year cycle
    assign w_leap = (w_q1 == 2'd3) && ((r6_q4 != 5'd24) || (r6_q100 == 2'd3));

    always_ff @(posedge i_clk) begin
        if (i_load[6]) begin
            r7_year <= w_year;
            r7_doy  <= w_doy[8:0];
            r7_leap <= w_leap;
            r7_hour <= r6_hour;
            r7_min  <= r6_min;
            r7_sec  <= r6_sec;
            r7_err  <= r6_err;
        end
    end

    // Stage 8: month from parallel compares against month starts
    always_comb begin
        for (int m = 0; m < 11; m++) begin
            w_ge[m] = r7_doy >= month_offset(4'(m + 2), r7_leap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[7]) begin
            r8_year  <= r7_year;
            r8_month <= 4'd1 + 4'($countones(w_ge));
            r8_doy   <= r7_doy;
            r8_leap  <= r7_leap;
            r8_hour  <= r7_hour;
            r8_min   <= r7_min;
            r8_sec   <= r7_sec;
            r8_err   <= r7_err;
        end
    end

    assign w_day = r8_doy - month_offset(r8_month, r8_leap) + 9'd1;

    assign o_cal.year   = r8_year;
    assign o_cal.month  = r8_month;
    assign o_cal.day    = w_day[4:0];
    assign o_cal.hour   = r8_hour;
    assign o_cal.minute = r8_min;
    assign o_cal.sec    = r8_sec;
    assign o_cal.err    = r8_err;
endmodule

[rtl/csc_to_sec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_to_sec: calendar-to-seconds datapath
// Five computing stages (century counts, day count, day total, day scaling,
// final sum) followed by delay stages to match the other direction.
// ----------------------------------------------------------------------------
module csc_to_sec (
    input  logic                              i_clk,
    input  logic [csc_pkg::NUM_STAGES-1:0]    i_load,
    input  logic [13:0]                       i_year,
    input  logic [3:0]                        i_month,
    input  logic [4:0]                        i_day,
    input  logic [4:0]                        i_hour,
    input  logic [5:0]                        i_minute,
    input  logic [5:0]                        i_sec,
    output logic [38:0]                       o_seconds
);
    import csc_pkg::*;

    localparam int DLY_DEPTH = NUM_STAGES - 5;

    // stage 1
    logic [13:0] w_n;
    logic [27:0] w_py;
    logic [27:0] w_pn;
    logic [13:0] r1_year;
    logic [13:0] r1_n;
    logic [7:0]  r1_qy;
    logic [7:0]  r1_qn;
    logic [3:0]  r1_month;
    logic [4:0]  r1_day;
    logic [4:0]  r1_hour;
    logic [5:0]  r1_min;
    logic [5:0]  r1_sec;
    // stage 2
    logic [13:0] w_yc;
    logic        w_cent;
    logic        w_leap;
    logic [22:0] w_days;
    logic [22:0] r2_days;
    logic [8:0]  r2_mo;
    logic [4:0]  r2_day;
    logic [4:0]  r2_hour;
    logic [5:0]  r2_min;
    logic [5:0]  r2_sec;
    // stage 3
    logic [24:0] w_dm1;
    logic [16:0] w_tod;
    logic        r3_dneg;
    logic [23:0] r3_dlow;
    logic [16:0] r3_tod;
    // stage 4
    logic [40:0] w_pd;
    logic [38:0] r4_prod;
    logic [16:0] r4_tod;
    // stage 5 and delay line
    logic [38:0] r5_total;
    logic [38:0] r_dly [DLY_DEPTH];

    // Stage 1: year / 100 for the leap rule, (year - 1) / 100 for the day count
    assign w_n  = i_year - 14'd1;
    assign w_py = 28'(i_year) * 28'(RECIP_100);
    assign w_pn = 28'(w_n) * 28'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r1_year  <= i_year;
            r1_n     <= w_n;
            r1_qy    <= w_py[27:20];
            r1_qn    <= w_pn[27:20];
            r1_month <= i_month;
            r1_day   <= i_day;
            r1_hour  <= i_hour;
            r1_min   <= i_minute;
            r1_sec   <= i_sec;
        end
    end

    // Stage 2: days before the year, days before the month
    assign w_yc   = 14'(r1_qy) * 14'd100;
    assign w_cent = (r1_year == w_yc);
    assign w_leap = ((r1_year[1:0] == 2'b00) && !w_cent) || (w_cent && (r1_qy[1:0] == 2'b00));
    assign w_days = 23'(r1_n) * 23'd365 + 23'(r1_n[13:2]) - 23'(r1_qn) + 23'(r1_qn[7:2]);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            // year zero shares the base of year one
            r2_days <= (r1_year == 14'd0) ? 23'd0 : w_days;
            r2_mo   <= month_offset(r1_month, w_leap);
            r2_day  <= r1_day;
            r2_hour <= r1_hour;
            r2_min  <= r1_min;
            r2_sec  <= r1_sec;
        end
    end

    // Stage 3: whole days elapsed (may be minus one), seconds into the day
    assign w_dm1 = 25'(r2_days) + 25'(r2_mo) + 25'(r2_day) - 25'd1;
    assign w_tod = 17'(r2_hour) * 17'd3600 + 17'(r2_min) * 17'd60 + 17'(r2_sec);

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r3_dneg <= w_dm1[24];
            r3_dlow <= w_dm1[23:0];
            r3_tod  <= w_tod;
        end
    end

    // Stage 4: scale days to seconds, wrap the minus-one-day case
    assign w_pd = 41'(r3_dlow) * 41'd86400;

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r4_prod <= r3_dneg ? NEG_DAY_SECS : w_pd[38:0];
            r4_tod  <= r3_tod;
        end
    end

    // Stage 5: final sum, modulo 2^39
    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r5_total <= r4_prod + 39'(r4_tod);
        end
    end

    // Hold the result in step with the calendar direction
    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r_dly[0] <= r5_total;
        end
        for (int k = 1; k < DLY_DEPTH; k++) begin
            if (i_load[5 + k]) begin
                r_dly[k] <= r_dly[k - 1];
            end
        end
    end

    assign o_seconds = r_dly[DLY_DEPTH - 1];
endmodule
